FILE: design/lpa_pkg.sv
// ----------------------------------------------------------------------------
// lpa_pkg: shared types and helpers for the Legendre accumulate pipeline
// Fixed-point helpers, the word carried from cell to cell, register indexes.
// ----------------------------------------------------------------------------
package lpa_pkg;

    localparam int MAX_DEGREE_DEF = 16;
    localparam int FRAC_P         = 24;
    localparam int DEG_W          = 5;
    localparam int NCNT_W         = 6;

    localparam logic signed [31:0] Q824_ONE = 32'sh0100_0000;

    localparam logic [1:0] REG_OFFSET = 2'd0;
    localparam logic [1:0] REG_SCALE  = 2'd1;
    localparam logic [1:0] REG_DEGREE = 2'd2;
    localparam logic [1:0] REG_WEIGHT = 2'd3;

    typedef struct packed {
        logic               vld;
        logic               flag;
        logic signed [31:0] x;
        logic signed [31:0] cur;
        logic signed [31:0] prev;
        logic signed [31:0] acc;
    } lpa_item_t;

    // round half up, then arithmetic shift right
    function automatic logic signed [79:0] rnd(input logic signed [79:0] v,
                                               input int unsigned s);
        logic signed [79:0] half;
        half = 80'sd1 <<< (s - 1);
        return (v + half) >>> s;
    endfunction

    function automatic logic ovf32(input logic signed [79:0] v);
        return (v > 80'sd2147483647) || (v < -80'sd2147483648);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
        logic signed [31:0] r;
        if (v > 80'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -80'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

FILE: design/lpa_front.sv
// ----------------------------------------------------------------------------
// lpa_front: sample normalization
// Subtract offset, multiply by scale, round and saturate to Q8.24.
// ----------------------------------------------------------------------------
module lpa_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_vld,
    input  logic signed [31:0]        sample_value,
    input  logic signed [31:0]        accum_in,
    input  logic signed [31:0]        offset,
    input  logic signed [31:0]        scale,
    output lpa_pkg::lpa_item_t        item
);

    logic               vld1_reg, vld2_reg;
    logic signed [32:0] diff_reg, diff_next;
    logic signed [31:0] acc1_reg, acc2_reg;
    logic signed [64:0] prod_reg, prod_next;
    lpa_pkg::lpa_item_t item_reg, item_next;
    logic signed [79:0] xr;

    always_comb
    begin
        diff_next = 33'(sample_value) - 33'(offset);
        prod_next = 65'(diff_reg) * 65'(scale);
        xr        = lpa_pkg::rnd(80'(prod_reg), 16);
        item_next.vld  = vld2_reg;
        item_next.flag = lpa_pkg::ovf32(xr);
        item_next.x    = lpa_pkg::sat32(xr);
        item_next.cur  = lpa_pkg::sat32(xr);
        item_next.prev = lpa_pkg::Q824_ONE;
        item_next.acc  = acc2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            item_reg <= '0;
        end
        else if (en)
        begin
            vld1_reg <= in_vld;
            vld2_reg <= vld1_reg;
            item_reg <= item_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            diff_reg <= diff_next;
            acc1_reg <= accum_in;
            prod_reg <= prod_next;
            acc2_reg <= acc1_reg;
        end
    end

    assign item = item_reg;

endmodule

FILE: design/lpa_cell.sv
// ----------------------------------------------------------------------------
// lpa_cell: one step of the three-term recurrence
// P(K+1) = ((2K+1) x P(K) - K P(K-1)) / (K+1), four register stages.
// ----------------------------------------------------------------------------
module lpa_cell #(
    parameter int K = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [lpa_pkg::NCNT_W-1:0] n,
    input  lpa_pkg::lpa_item_t        item_in,
    output lpa_pkg::lpa_item_t        item_out
);

    localparam int                 D     = K + 1;
    localparam logic signed [24:0] RECIP = 25'((64'd16777216 + D / 2) / D);
    localparam logic signed [7:0]  C1    = 8'(2 * K + 1);
    localparam logic signed [7:0]  C0    = 8'(K);

    logic               act;
    lpa_pkg::lpa_item_t a_reg, b_reg, b_next, c_reg, d_reg, d_next;
    logic signed [63:0] a_prod_reg, a_prod_next;
    logic signed [39:0] b_num_reg, b_num_next;
    logic signed [64:0] c_prod_reg, c_prod_next;
    logic signed [79:0] tr, nr;
    logic signed [31:0] t;

    assign act = n > lpa_pkg::NCNT_W'(K);

    always_comb
    begin
        a_prod_next = 64'(item_in.x) * 64'(item_in.cur);

        tr          = lpa_pkg::rnd(80'(a_prod_reg), lpa_pkg::FRAC_P);
        t           = lpa_pkg::sat32(tr);
        b_num_next  = 40'(t) * 40'(C1) - 40'(a_reg.prev) * 40'(C0);
        b_next      = a_reg;
        b_next.flag = a_reg.flag | (act & lpa_pkg::ovf32(tr));

        c_prod_next = 65'(b_num_reg) * 65'(RECIP);

        nr          = lpa_pkg::rnd(80'(c_prod_reg), lpa_pkg::FRAC_P);
        d_next      = c_reg;
        if (act)
        begin
            d_next.flag = c_reg.flag | lpa_pkg::ovf32(nr);
            d_next.prev = c_reg.cur;
            d_next.cur  = lpa_pkg::sat32(nr);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
            b_reg <= '0;
            c_reg <= '0;
            d_reg <= '0;
        end
        else if (en)
        begin
            a_reg <= item_in;
            b_reg <= b_next;
            c_reg <= b_reg;
            d_reg <= d_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_prod_reg <= a_prod_next;
            b_num_reg  <= b_num_next;
            c_prod_reg <= c_prod_next;
        end
    end

    assign item_out = d_reg;

endmodule

FILE: design/lpa_back.sv
// ----------------------------------------------------------------------------
// lpa_back: weighting and accumulation
// Multiply P by weight, add the accumulator, saturate, hold the result word.
// ----------------------------------------------------------------------------
module lpa_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic [lpa_pkg::NCNT_W-1:0] n,
    input  logic signed [31:0]         weight,
    input  lpa_pkg::lpa_item_t         item,
    output logic                       out_vld,
    output logic signed [31:0]         accum_out,
    output logic                       saturated
);

    logic               vld1_reg, flag1_reg, out_vld_reg, sat_reg;
    logic signed [31:0] acc1_reg, p;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [31:0] accum_out_reg;
    logic signed [79:0] sum;

    always_comb
    begin
        p         = (n == '0) ? lpa_pkg::Q824_ONE : item.cur;
        prod_next = 64'(p) * 64'(weight);
        sum       = 80'(acc1_reg) + lpa_pkg::rnd(80'(prod_reg), lpa_pkg::FRAC_P);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld1_reg    <= item.vld;
            out_vld_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg      <= prod_next;
            acc1_reg      <= item.acc;
            flag1_reg     <= item.flag;
            accum_out_reg <= lpa_pkg::sat32(sum);
            sat_reg       <= flag1_reg | lpa_pkg::ovf32(sum);
        end
    end

    assign out_vld   = out_vld_reg;
    assign accum_out = accum_out_reg;
    assign saturated = sat_reg;

endmodule

FILE: design/legendre_pointwise_accumulate.sv
// ----------------------------------------------------------------------------
// legendre_pointwise_accumulate: weighted Legendre term added per grid cell
// Normalizes a sample, evaluates P_degree by recurrence, accumulates weight*P.
// ----------------------------------------------------------------------------
// Input stream s_*: one word per cell, sample and current accumulator.
// Output stream m_*: one word per input word, in order, the saturated sum in
// m_tdata and the saturation flag in m_tuser.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (offset, scale, degree, weight) at the clock edge; write only while idle.
// Pipeline: three normalization stages, four stages per recurrence cell for
// MAX_DEGREE-1 cells, two weighting stages. Cells above the configured degree
// pass the word through unchanged, so latency does not depend on degree.
// Throughput: one word per cycle while the output is not stalled, set by the
// fully pipelined cell chain.
// Stall: when the output word is held and m_tready is low, the whole chain
// freezes and s_tready drops; no word is lost.
// Reset: rst_n clears all valid flags and loads the register defaults
// (offset 0, scale 1.0, degree 0, weight 1.0).
// ----------------------------------------------------------------------------
module legendre_pointwise_accumulate #(
    parameter int MAX_DEGREE = lpa_pkg::MAX_DEGREE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [31:0] sample_value, [63:32] accum_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] accum_out
    output logic        m_tuser,    // [0] saturated
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic                       en;
    logic signed [31:0]         offset_reg, scale_reg, weight_reg;
    logic [lpa_pkg::DEG_W-1:0]  degree_reg;
    logic [lpa_pkg::NCNT_W-1:0] n;
    logic signed [31:0]         accum_out;
    lpa_pkg::lpa_item_t         chain [MAX_DEGREE];

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= 32'sd0;
            scale_reg  <= 32'sh0100_0000;
            degree_reg <= '0;
            weight_reg <= 32'sh0001_0000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lpa_pkg::REG_OFFSET: offset_reg <= cfg_data;
                lpa_pkg::REG_SCALE:  scale_reg  <= cfg_data;
                lpa_pkg::REG_DEGREE: degree_reg <= cfg_data[lpa_pkg::DEG_W-1:0];
                lpa_pkg::REG_WEIGHT: weight_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign n = ({1'b0, degree_reg} > lpa_pkg::NCNT_W'(MAX_DEGREE))
             ? lpa_pkg::NCNT_W'(MAX_DEGREE) : {1'b0, degree_reg};

    lpa_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_vld       (s_tvalid && s_tready),
        .sample_value (s_tdata[31:0]),
        .accum_in     (s_tdata[63:32]),
        .offset       (offset_reg),
        .scale        (scale_reg),
        .item         (chain[0])
    );

    for (genvar i = 0; i < MAX_DEGREE - 1; i++)
    begin : g_cell
        lpa_cell #(
            .K (i + 1)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .n        (n),
            .item_in  (chain[i]),
            .item_out (chain[i+1])
        );
    end

    lpa_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .n         (n),
        .weight    (weight_reg),
        .item      (chain[MAX_DEGREE-1]),
        .out_vld   (m_tvalid),
        .accum_out (accum_out),
        .saturated (m_tuser)
    );

    assign m_tdata = accum_out;

endmodule

FILE: design/lpa_checker.sv
// ----------------------------------------------------------------------------
// lpa_checker: port-level checks for the Legendre accumulate block
// Output hold under stall, flow control and reset behavior.
// ----------------------------------------------------------------------------
module lpa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed under stall");

    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output flow");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |=> $stable(m_tvalid))
        else $error("pipeline advanced while stalled");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind legendre_pointwise_accumulate lpa_checker u_lpa_checker (.*);

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for legendre_pointwise_accumulate
// Streams cells through the block under several register settings and idle
// patterns, predicts every output word in fixed point and compares in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int     CELL_MAX_DEGREE = lpa_pkg::MAX_DEGREE_DEF;
    localparam int     PIPE_LATENCY    = 5 + 4 * (CELL_MAX_DEGREE - 1);
    localparam int     DRAIN_CYCLES    = PIPE_LATENCY + 10;
    localparam int     HOLD_CYCLES     = 400;
    localparam int     PHASE_CELLS     = 140;
    localparam longint Q_ONE           = longint'(1) << lpa_pkg::FRAC_P;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [31:0] acc;
        logic [31:0] sample;
    } cell_in_t;

    typedef struct packed {
        logic        sat;
        logic [31:0] sum;
    } cell_out_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata   = '0;    // [31:0] sample_value, [63:32] accum_in
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [31:0] m_tdata;           // [31:0] accum_out
    logic        m_tuser;           // [0] saturated
    logic        cfg_we    = 1'b0;
    logic [1:0]  cfg_index = lpa_pkg::REG_OFFSET;
    logic [31:0] cfg_data  = '0;

    logic [31:0] cfg_offset = 32'd0;
    logic [31:0] cfg_scale  = 32'd16777216;
    logic [4:0]  cfg_degree = 5'd0;
    logic [31:0] cfg_weight = 32'd65536;

    cell_in_t   pending_cells[$];
    cell_out_t  expected_sums[$];
    idle_mode_t idle_mode   = IDLE_NONE;
    int         errors      = 0;
    logic       src_taken   = 1'b0;
    int         hold_req    = 0;
    int         hold_seen   = 0;
    int         hold_left   = 0;
    longint     cell_span   = 0;

    legendre_pointwise_accumulate u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint round_half_up(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip32(input longint v, inout logic flag);
        longint r;
        r = v;
        if (v > longint'(32'sh7FFF_FFFF))
        begin
            flag = 1'b1;
            r = longint'(32'sh7FFF_FFFF);
        end
        else if (v < longint'(32'sh8000_0000))
        begin
            flag = 1'b1;
            r = longint'(32'sh8000_0000);
        end
        return r;
    endfunction

    function automatic cell_out_t predict_cell(input logic [31:0] sample, input logic [31:0] acc);
        longint    diff;
        longint    x;
        longint    prev;
        longint    cur;
        longint    t;
        longint    num;
        longint    recip;
        longint    wp;
        longint    sum;
        int        n;
        logic      sat;
        cell_out_t r;
        sat  = 1'b0;
        diff = longint'($signed(sample)) - longint'($signed(cfg_offset));
        x    = clip32(round_half_up(diff * longint'($signed(cfg_scale)), 16), sat);
        n    = (cfg_degree > CELL_MAX_DEGREE) ? CELL_MAX_DEGREE : int'(cfg_degree);
        prev = Q_ONE;
        cur  = (n == 0) ? Q_ONE : x;
        for (int k = 1; k < n; k++)
        begin
            t     = clip32(round_half_up(x * cur, lpa_pkg::FRAC_P), sat);
            num   = longint'(2 * k + 1) * t - longint'(k) * prev;
            recip = (Q_ONE + longint'((k + 1) / 2)) / longint'(k + 1);
            prev  = cur;
            cur   = clip32(round_half_up(num * recip, lpa_pkg::FRAC_P), sat);
        end
        wp    = round_half_up(cur * longint'($signed(cfg_weight)), lpa_pkg::FRAC_P);
        sum   = clip32(longint'($signed(acc)) + wp, sat);
        r.sum = sum[31:0];
        r.sat = sat;
        return r;
    endfunction

    function automatic logic roll_idle(input idle_mode_t m, input logic sink_side);
        int pct;
        pct = 0;
        if (m == IDLE_BOTH)
            pct = 23;
        else if ((m == IDLE_SRC && !sink_side) || (m == IDLE_SNK && sink_side))
            pct = 84;
        return $urandom_range(99) < pct;
    endfunction

    // driver: hold a word until taken, then offer the next one or idle
    always @(negedge clk)
    begin : drive_cells
        cell_in_t c;
        if (rst_n && (src_taken || !s_tvalid))
        begin
            if (pending_cells.size() != 0 && !roll_idle(idle_mode, 1'b0))
            begin
                c = pending_cells.pop_front();
                s_tdata  <= {c.acc, c.sample};
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver: long hold-off on request, otherwise random stalls
    always @(negedge clk)
    begin
        if (hold_seen != hold_req)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end
        else
            m_tready <= rst_n && !roll_idle(idle_mode, 1'b1);
    end

    // monitor: predict on input words, compare on output words
    always @(posedge clk)
    begin : watch_cells
        cell_out_t want;
        src_taken = s_tvalid && s_tready;
        if (src_taken)
            expected_sums.insert(expected_sums.size(),
                                 predict_cell(s_tdata[31:0], s_tdata[63:32]));
        if (m_tvalid && m_tready)
        begin
            if (expected_sums.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word: expected none, actual sum %h sat %b",
                         $time, m_tdata, m_tuser);
            end
            else
            begin
                want = expected_sums.pop_front();
                if (m_tdata !== want.sum)
                begin
                    errors++;
                    $display("%0t: accum_out mismatch: expected %h, actual %h",
                             $time, want.sum, m_tdata);
                end
                if (m_tuser !== want.sat)
                begin
                    errors++;
                    $display("%0t: saturated mismatch: expected %b, actual %b",
                             $time, want.sat, m_tuser);
                end
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            lpa_pkg::REG_OFFSET: cfg_offset = data;
            lpa_pkg::REG_SCALE:  cfg_scale  = data;
            lpa_pkg::REG_DEGREE: cfg_degree = data[4:0];
            lpa_pkg::REG_WEIGHT: cfg_weight = data;
            default:    ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_cell(input logic [31:0] sample, input logic [31:0] acc);
        cell_in_t c;
        c.sample = sample;
        c.acc    = acc;
        pending_cells.insert(pending_cells.size(), c);
    endtask

    task automatic wait_drained();
        while (pending_cells.size() != 0 || s_tvalid)
            @(posedge clk);
        while (expected_sums.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int unsigned deg_plan[12];
        longint      scl;
        longint      tmp;
        longint      wgt;
        logic [31:0] samp;
        logic [31:0] acc;
        int          sel;

        deg_plan = '{1, 2, 3, 5, 8, 16, 31, 4, 12, 0, 17, 7};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: degree zero, x saturation with P still one, sum clipping
        add_cell(32'h0000_0000, 32'h0000_0000);
        add_cell(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_cell(32'h8000_0000, 32'h8000_0000);
        add_cell(32'h0000_8000, 32'h7FFF_0000);
        add_cell(32'hFFFF_FFFF, 32'h8000_0001);
        wait_drained();

        write_reg(lpa_pkg::REG_DEGREE, 32'd1);
        write_reg(lpa_pkg::REG_OFFSET, 32'h8000_0000);
        write_reg(lpa_pkg::REG_SCALE,  32'h7FFF_FFFF);
        write_reg(lpa_pkg::REG_WEIGHT, 32'h7FFF_FFFF);
        @(posedge clk);
        add_cell(32'h7FFF_FFFF, 32'h0000_0000);
        add_cell(32'h8000_0000, 32'h0000_0000);
        add_cell(32'h8000_0001, 32'h8000_0000);
        add_cell(32'h8000_0100, 32'h1234_5678);
        wait_drained();

        // degree above the maximum clamps
        write_reg(lpa_pkg::REG_DEGREE, 32'd31);
        write_reg(lpa_pkg::REG_OFFSET, 32'h7FFF_FFFF);
        write_reg(lpa_pkg::REG_SCALE,  32'h8000_0000);
        write_reg(lpa_pkg::REG_WEIGHT, 32'h8000_0000);
        @(posedge clk);
        add_cell(32'h7FFF_FFFF, 32'h0000_0000);
        add_cell(32'h7FFF_FFFE, 32'h7FFF_FFFF);
        add_cell(32'h8000_0000, 32'h8000_0000);
        add_cell(32'h7FFF_FF00, 32'h0001_0000);
        wait_drained();

        write_reg(lpa_pkg::REG_DEGREE, 32'd16);
        write_reg(lpa_pkg::REG_OFFSET, 32'h0000_0000);
        write_reg(lpa_pkg::REG_SCALE,  32'h0100_0000);
        write_reg(lpa_pkg::REG_WEIGHT, 32'h0001_0000);
        @(posedge clk);
        add_cell(32'h0001_0000, 32'h0000_0000);
        add_cell(32'hFFFF_0000, 32'h0000_0000);
        add_cell(32'h0000_8000, 32'h0000_0000);
        add_cell(32'h0000_0000, 32'hFFFF_FFFF);
        add_cell(32'h0000_4000, 32'h0010_0000);
        wait_drained();

        write_reg(lpa_pkg::REG_WEIGHT, 32'h0000_0000);
        @(posedge clk);
        add_cell(32'h0000_C000, 32'h7FFF_FFFF);
        add_cell(32'h8000_0000, 32'h8000_0000);
        wait_drained();

        for (int ph = 0; ph < 12; ph++)
        begin
            cell_span = longint'(1) << $urandom_range(10, 30);
            scl = (longint'(1) << 40) / cell_span;
            if ($urandom_range(3) == 0)
                scl = -scl;
            wgt = longint'($signed($urandom)) >>> (31 - $urandom_range(8, 24));
            write_reg(lpa_pkg::REG_OFFSET, $urandom);
            write_reg(lpa_pkg::REG_SCALE,  scl[31:0]);
            write_reg(lpa_pkg::REG_DEGREE, deg_plan[ph]);
            write_reg(lpa_pkg::REG_WEIGHT, wgt[31:0]);
            if (ph == 5)
                write_reg(lpa_pkg::REG_WEIGHT, 32'h7FFF_FFFF);
            if (ph == 6)
                write_reg(lpa_pkg::REG_WEIGHT, 32'h8000_0000);
            if (ph == 9)
            begin
                write_reg(lpa_pkg::REG_SCALE,  32'h8000_0000);
                write_reg(lpa_pkg::REG_OFFSET, 32'h7FFF_FFFF);
            end
            if (ph == 10)
                write_reg(lpa_pkg::REG_SCALE, 32'h7FFF_FFFF);
            @(posedge clk);
            idle_mode = idle_mode_t'(ph % 4);
            // fill the pipe against a stopped receiver
            if (ph == 0)
                hold_req++;
            for (int i = 0; i < PHASE_CELLS; i++)
            begin
                if ($urandom_range(3) != 0)
                begin
                    tmp  = longint'($signed(cfg_offset)) +
                           longint'($urandom_range(0, 32'(2 * cell_span))) - cell_span;
                    samp = tmp[31:0];
                end
                else
                    samp = $urandom;
                sel = $urandom_range(9);
                if (sel < 7)
                    acc = $signed($urandom) >>> 11;
                else if (sel < 9)
                    acc = $urandom;
                else if ($urandom_range(1))
                    acc = 32'h7FFF_FFFF - $urandom_range(255);
                else
                    acc = 32'h8000_0000 + $urandom_range(255);
                add_cell(samp, acc);
            end
            wait_drained();
        end

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: sim.f
design/lpa_pkg.sv
design/lpa_front.sv
design/lpa_cell.sv
design/lpa_back.sv
design/legendre_pointwise_accumulate.sv
design/lpa_checker.sv
tb/tb.sv
